[hw/rtl/kcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_pkg: shared types and constants of the k-closest stream selector
// Widths of the data path, register map, cell control and scan token types.
// ----------------------------------------------------------------------------
package kcs_pkg;

  localparam int VAL_W  = 32;
  localparam int DIST_W = 32;
  localparam int KEEP_W = 5;
  localparam int ADDR_W = 3;

  // register select is paddr[2]: one 32-bit register every four bytes
  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_KEEP   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  // per-cell update command; load wins over shift
  typedef struct packed {
    logic load;
    logic shift;
  } cell_op_t;

  // running worst distance carried along the cell row
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] worst_dist;
  } scan_t;

endpackage : kcs_pkg
`default_nettype wire

[hw/rtl/kcs_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_cell: one entry of the selector's cell row
// Holds one value and its distance, takes a new item or its right neighbor's
// entry, and forwards the worst-distance scan token one place per cycle.
// ----------------------------------------------------------------------------
module kcs_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  kcs_pkg::cell_op_t            op,
  input  wire  [kcs_pkg::VAL_W-1:0]    new_value,
  input  wire  [kcs_pkg::DIST_W-1:0]   new_dist,
  input  wire  [kcs_pkg::VAL_W-1:0]    right_value,
  input  wire  [kcs_pkg::DIST_W-1:0]   right_dist,
  input  wire                          occupied,
  input  kcs_pkg::scan_t               scan_in,
  input  wire  [IDX_W-1:0]             scan_in_idx,
  output logic [kcs_pkg::VAL_W-1:0]    value,
  output logic [kcs_pkg::DIST_W-1:0]   held_dist,
  output kcs_pkg::scan_t               scan_out,
  output logic [IDX_W-1:0]             scan_out_idx
);
  import kcs_pkg::*;

  logic take_own;

  // later entries win ties, so the most recent worst entry is chosen
  assign take_own = occupied && (held_dist >= scan_in.worst_dist);

  // entry storage: load new item, move up from the right, or hold
  always_ff @(posedge clk) begin
    if (op.load) begin
      value     <= new_value;
      held_dist <= new_dist;
    end else if (op.shift) begin
      value     <= right_value;
      held_dist <= right_dist;
    end
  end

  // scan token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    if (take_own) begin
      scan_out.worst_dist <= held_dist;
      scan_out_idx        <= IDX_W'(CELL_IDX);
    end else begin
      scan_out.worst_dist <= scan_in.worst_dist;
      scan_out_idx        <= scan_in_idx;
    end
  end

endmodule : kcs_cell
`default_nettype wire

[hw/rtl/k_closest_stream_selector_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// k_closest_stream_selector_top: keeps the values closest to a target
// Streams signed samples in, holds the keep_count closest in a row of cells,
// and streams them out in arrival order on the sample marked last.
// ----------------------------------------------------------------------------
// An appended sample (store below keep_count) fills the next free cell. Once
// the store is full, the worst-distance token walks the cell row one cell per
// cycle; a closer sample then drops the worst entry, the row closes up and the
// sample goes in at the end, else the sample is dropped. After a sample marked
// tlast the held values leave from cell 0 at one transfer per cycle while
// m_tready is high; the input is held off during a scan and during that drain.
// The output register lets the next sample in before the final value is taken.
// Registers: 0x0 target_value (signed), 0x4 keep_count (0 acts as 1, values
// above CAPACITY act as CAPACITY). Write them only while the block is idle.
module k_closest_stream_selector_top #(
  parameter int CAPACITY = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  // input stream
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [kcs_pkg::VAL_W-1:0]    s_tdata,   // [31:0] sample_value
  input  wire                          s_tlast,   // end_of_set
  // output stream
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [kcs_pkg::VAL_W-1:0]    m_tdata,   // [31:0] kept_value
  output logic                         m_tlast,   // final_flag
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [kcs_pkg::ADDR_W-1:0]   paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import kcs_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  state_t state, state_next;

  logic [VAL_W-1:0]  target_value;
  logic [KEEP_W-1:0] keep_count;
  logic [CNT_W-1:0]  held_count, held_count_next;

  logic [VAL_W-1:0]  samp_value;
  logic [DIST_W-1:0] samp_dist;
  logic              samp_last;

  logic              in_xfer, cfg_wr, out_free, drain_pop;
  logic              store_full, append, start_scan, evict, scan_done;
  logic [CMP_W-1:0]  keep_eff;
  logic [VAL_W:0]    diff_ab, diff_ba;
  logic [DIST_W-1:0] in_dist;
  logic [VAL_W-1:0]  new_value;
  logic [DIST_W-1:0] new_dist;
  logic [CNT_W-1:0]  last_pos;
  logic [CNT_W-1:0]  worst_pos;

  logic [VAL_W-1:0]  cell_value [CAPACITY];
  logic [DIST_W-1:0] cell_dist  [CAPACITY];
  scan_t             cell_scan  [CAPACITY];
  logic [IDX_W-1:0]  cell_idx   [CAPACITY];
  logic [CAPACITY-1:0] scan_valid_vec;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value <= '0;
      keep_count   <= KEEP_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TARGET) begin
        target_value <= pwdata[VAL_W-1:0];
      end else begin
        keep_count <= pwdata[KEEP_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_TARGET) begin
      prdata = target_value;
    end else begin
      prdata = {{(32 - KEEP_W){1'b0}}, keep_count};
    end
  end

  // clamp keep count to 1..CAPACITY
  always_comb begin
    if (keep_count == '0) begin
      keep_eff = CMP_W'(1);
    end else if (CMP_W'(keep_count) > CMP_W'(CAPACITY)) begin
      keep_eff = CMP_W'(CAPACITY);
    end else begin
      keep_eff = CMP_W'(keep_count);
    end
  end

  assign store_full = CMP_W'(held_count) >= keep_eff;

  // absolute distance in offset binary; both differences in parallel
  assign diff_ab = {1'b0, ~s_tdata[VAL_W-1], s_tdata[VAL_W-2:0]}
                 - {1'b0, ~target_value[VAL_W-1], target_value[VAL_W-2:0]};
  assign diff_ba = {1'b0, ~target_value[VAL_W-1], target_value[VAL_W-2:0]}
                 - {1'b0, ~s_tdata[VAL_W-1], s_tdata[VAL_W-2:0]};
  assign in_dist = diff_ab[VAL_W] ? diff_ba[DIST_W-1:0] : diff_ab[DIST_W-1:0];

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // sample capture for the scan path
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      samp_value <= s_tdata;
      samp_dist  <= in_dist;
      samp_last  <= s_tlast;
    end
  end

  // scan result at the end of the row
  assign scan_done = cell_scan[CAPACITY-1].valid;
  assign worst_pos = CNT_W'(cell_idx[CAPACITY-1]);
  assign last_pos  = held_count - CNT_W'(1);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
    end
  end

  // next state and control
  always_comb begin
    state_next      = state;
    held_count_next = held_count;
    s_tready        = 1'b0;
    append          = 1'b0;
    start_scan      = 1'b0;
    evict           = 1'b0;
    drain_pop       = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_xfer) begin
          if (!store_full) begin
            append          = 1'b1;
            held_count_next = held_count + CNT_W'(1);
            if (s_tlast) begin
              state_next = ST_DRAIN;
            end
          end else begin
            start_scan = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          evict      = samp_dist < cell_scan[CAPACITY-1].worst_dist;
          state_next = samp_last ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          drain_pop       = 1'b1;
          held_count_next = held_count - CNT_W'(1);
          if (held_count == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // new entry comes straight from the port on append, else from capture
  assign new_value = (state == ST_IDLE) ? s_tdata : samp_value;
  assign new_dist  = (state == ST_IDLE) ? in_dist : samp_dist;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_op_t          op;
    scan_t             scan_in;
    logic [IDX_W-1:0]  scan_in_idx;
    logic [VAL_W-1:0]  right_value;
    logic [DIST_W-1:0] right_dist;
    logic              occupied;

    assign occupied = CNT_W'(i) < held_count;
    assign op.load  = (append && (held_count == CNT_W'(i)))
                   || (evict && (last_pos == CNT_W'(i)));
    assign op.shift = (evict && (CNT_W'(i) >= worst_pos) && (CNT_W'(i) < last_pos))
                   || drain_pop;

    if (i == 0) begin : g_head
      assign scan_in.valid      = start_scan;
      assign scan_in.worst_dist = '0;
      assign scan_in_idx        = '0;
    end else begin : g_body
      assign scan_in     = cell_scan[i-1];
      assign scan_in_idx = cell_idx[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_dist  = cell_dist[i];
    end else begin : g_link
      assign right_value = cell_value[i+1];
      assign right_dist  = cell_dist[i+1];
    end

    kcs_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .op           (op),
      .new_value    (new_value),
      .new_dist     (new_dist),
      .right_value  (right_value),
      .right_dist   (right_dist),
      .occupied     (occupied),
      .scan_in      (scan_in),
      .scan_in_idx  (scan_in_idx),
      .value        (cell_value[i]),
      .held_dist    (cell_dist[i]),
      .scan_out     (cell_scan[i]),
      .scan_out_idx (cell_idx[i])
    );

    assign scan_valid_vec[i] = cell_scan[i].valid;
  end

  // output register: drain from cell 0, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (drain_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_pop) begin
      m_tdata <= cell_value[0];
      m_tlast <= (held_count == CNT_W'(1));
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(scan_valid_vec))
    else $error("more than one scan token in the cell row");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (drain_pop && (held_count == CNT_W'(1)))
      |=> (m_tvalid && m_tlast && (held_count == '0) && (state == ST_IDLE)))
    else $error("final transfer not flagged or store not cleared");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (held_count != '0))
    else $error("scan running on an empty store");

endmodule : k_closest_stream_selector_top
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stream check of the k-closest stream selector
// Feeds sets of signed samples with random gaps, keeps its own copy of the
// closest-value store, and compares every transfer out against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CAPACITY = 16;
  // no transfer for this long means the block is stuck; well above the longest
  // stall, the long receiver hold-off and a full-row scan
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;

  localparam logic [kcs_pkg::ADDR_W-1:0] TARGET_ADDR = {kcs_pkg::REG_TARGET, 2'b00};
  localparam logic [kcs_pkg::ADDR_W-1:0] KEEP_ADDR   = {kcs_pkg::REG_KEEP, 2'b00};

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } sample_t;

  typedef struct packed {
    logic [31:0] value;
    logic        final_flag;
  } kept_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [31:0] s_tdata = '0;  // [31:0] sample_value
  logic        s_tlast = 1'b0;  // end_of_set
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [31:0] m_tdata;  // [31:0] kept_value
  wire         m_tlast;  // final_flag
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [kcs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  sample_t     sample_queue[$];
  kept_t       kept_due[$];

  // predictor state: register copies and the held store
  logic [31:0] model_target = '0;
  logic [4:0]  model_keep = 5'd1;
  logic [31:0] store_val[CAPACITY];
  logic [31:0] store_dist[CAPACITY];
  int          store_count = 0;

  int          send_idle_pct = 30;
  int          recv_idle_pct = 82;
  int          hold_trigger = 0;
  int          inputs_accepted = 0;
  bit          input_taken = 1'b0;
  int          quiet_cycles = 0;
  int          error_count = 0;

  k_closest_stream_selector_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Fold one accepted sample into the store; on end of set queue the held values.
  function automatic void select_closest(input logic [31:0] v, input logic last);
    logic signed [32:0] diff;
    logic [31:0] d;
    int k;
    int worst;
    kept_t item;
    diff = $signed({v[31], v}) - $signed({model_target[31], model_target});
    d = diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
    k = (model_keep == 0) ? 1 : (model_keep > CAPACITY) ? CAPACITY : int'(model_keep);
    if (store_count < k) begin
      store_val[store_count] = v;
      store_dist[store_count] = d;
      store_count++;
    end else if (store_count > 0) begin
      // latest of equal worst distances loses
      worst = 0;
      for (int i = 1; i < store_count; i++) begin
        if (store_dist[i] >= store_dist[worst]) worst = i;
      end
      if (d < store_dist[worst]) begin
        for (int i = worst; i + 1 < store_count; i++) begin
          store_val[i] = store_val[i + 1];
          store_dist[i] = store_dist[i + 1];
        end
        store_val[store_count - 1] = v;
        store_dist[store_count - 1] = d;
      end
    end
    if (last) begin
      for (int i = 0; i < store_count; i++) begin
        item.value = store_val[i];
        item.final_flag = (i + 1 == store_count);
        kept_due = {kept_due, item};
      end
      store_count = 0;
    end
  endfunction

  // Sender: hold the word until taken, then load the next or idle.
  always @(negedge clk) begin : feed
    sample_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || input_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = sample_queue.pop_front();
        s_tdata <= nxt.value;
        s_tlast <= nxt.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once the trigger is hit.
  always @(negedge clk) begin : drain
    int hold_left;
    bit hold_done;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (!hold_done && hold_trigger != 0 && inputs_accepted >= hold_trigger) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on input transfers, check output transfers, watch for hangs.
  always @(posedge clk) begin : watch
    kept_t due;
    input_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        input_taken = 1'b1;
        inputs_accepted++;
        select_closest(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (kept_due.size() == 0) begin
          flag_error($sformatf("unexpected transfer out, kept_value %h", m_tdata));
        end else begin
          due = kept_due.pop_front();
          if (m_tdata !== due.value)
            flag_error($sformatf("kept_value got %h want %h", m_tdata, due.value));
          if (m_tlast !== due.final_flag)
            flag_error($sformatf("final_flag got %b want %b", m_tlast, due.final_flag));
        end
      end
      if (input_taken || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Wait until every sample is taken and every result is out, then let a
  // full-row scan finish.
  task automatic settle();
    while (sample_queue.size() != 0 || s_tvalid || kept_due.size() != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);
  endtask

  task automatic reg_write(input logic [kcs_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == TARGET_ADDR) model_target = data;
    else model_keep = data[4:0];
  endtask

  task automatic configure(input logic [31:0] tgt, input logic [4:0] keep);
    settle();
    reg_write(TARGET_ADDR, tgt);
    reg_write(KEEP_ADDR, {27'd0, keep});
  endtask

  task automatic add_sample(input logic [31:0] v, input logic last);
    sample_t s;
    s.value = v;
    s.last = last;
    sample_queue = {sample_queue, s};
  endtask

  // Mostly values near the target, so ties and evictions are frequent.
  function automatic logic [31:0] draw_value();
    int r;
    r = $urandom_range(9);
    if (r < 6) return model_target + 32'($urandom_range(16)) - 32'd8;
    if (r < 8) return $urandom();
    case ($urandom_range(3))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return 32'd0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] draw_target();
    case ($urandom_range(7))
      0: return MOST_NEG;
      1: return MOST_POS;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] draw_keep();
    case ($urandom_range(9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd17;
      4: return 5'd31;
      default: return 5'($urandom_range(2, 8));
    endcase
  endfunction

  // Sets of random length; the closing set may stay open across the next write.
  task automatic random_phase(input logic [31:0] tgt, input logic [4:0] keep,
                              input int budget, input bit may_leave_open);
    int sent;
    int len;
    int k;
    bit close;
    configure(tgt, keep);
    k = (keep == 0) ? 1 : (keep > CAPACITY) ? CAPACITY : int'(keep);
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(1, 2 * k + 2);
      close = !(may_leave_open && sent + len >= budget && $urandom_range(2) == 0);
      for (int i = 0; i < len; i++) add_sample(draw_value(), close && (i == len - 1));
      sent += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // keep count zero acts as one; a farther extreme is dropped
    configure(32'd0, 5'd0);
    add_sample(MOST_POS, 1'b0);
    add_sample(MOST_NEG, 1'b0);
    add_sample(32'd3, 1'b1);

    // equal to worst is dropped; among tied worst the newest goes
    configure(32'd10, 5'd3);
    add_sample(32'd12, 1'b0);
    add_sample(32'd8, 1'b0);
    add_sample(32'd13, 1'b0);
    add_sample(32'd7, 1'b0);
    add_sample(32'd11, 1'b0);
    add_sample(32'd9, 1'b1);

    // keep count above capacity saturates; leave the set open
    configure(MOST_NEG, 5'd31);
    add_sample(MOST_POS, 1'b0);
    add_sample(32'hffff_ffff, 1'b0);
    add_sample(MOST_NEG, 1'b0);

    // lower the keep count and move the target mid-set: old distances stay
    configure(MOST_POS, 5'd2);
    add_sample(32'h7fff_fffe, 1'b0);
    add_sample(32'd0, 1'b1);

    configure(32'hffff_ffff, 5'd1);
    add_sample(32'd5, 1'b0);
    add_sample(32'hffff_fffd, 1'b1);

    // set of one at full keep count
    configure(32'h1234_5678, 5'd16);
    add_sample(32'h8765_4321, 1'b1);

    random_phase(draw_target(), draw_keep(), 13, 1'b1);
    random_phase(draw_target(), draw_keep(), 13, 1'b1);

    settle();
    send_idle_pct = 82;
    recv_idle_pct = 30;
    random_phase(draw_target(), draw_keep(), 13, 1'b1);
    random_phase(draw_target(), draw_keep(), 13, 1'b1);

    // no idling; hold off the receiver so the block backs up into its input
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger = inputs_accepted + 3;
    random_phase(draw_target(), 5'd3, 13, 1'b1);
    random_phase(draw_target(), draw_keep(), 13, 1'b0);

    settle();
    if (error_count == 0 && kept_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
